FILE: rtl/trem_pkg.sv
package trem_pkg;

  localparam int TICK_W         = 24;
  localparam int MODE_W         = 2;
  localparam int SAMPLE_W       = 16;
  localparam int FREQ_W         = 16;
  localparam int ELAPSED_W      = 25;
  localparam int INTERVAL_MAX_W = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int MS_W           = 10;

  localparam logic [TICK_W-1:0]    TICK_RATE_RESET = 24'd100000;
  localparam logic [MS_W-1:0]      MS_PER_S        = 10'd1000;
  localparam logic [FREQ_W-1:0]    FREQ_MAX        = 16'hFFFF;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = 25'h1FF_FFFF;

  // Register index, taken from paddr[2]
  localparam logic REG_TICK_RATE = 1'b0;

  typedef enum logic [1:0] {
    MODE_MARK    = 2'd0,
    MODE_FREQ    = 2'd1,
    MODE_ELAPSED = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_FREQ,
    OP_ELAPSED
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_BIAS,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SAMPLE_W-1:0] counter_value;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0]    freq_hz;
    logic [ELAPSED_W-1:0] elapsed_ms_q8;
    logic                 freq_saturated;
    logic                 freq_fresh;
  } out_item_t;

  typedef struct packed {
    op_e                       op;
    logic [INTERVAL_MAX_W-1:0] interval;
  } cmd_t;

endpackage

FILE: rtl/trem_front.sv
module trem_front #(
  parameter int COUNTER_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  trem_pkg::in_item_t in_item_i,
  input  logic              full_i,
  output logic              push_o,
  output trem_pkg::cmd_t    cmd_o
);
  import trem_pkg::*;

  logic [COUNTER_BITS-1:0]   mark_q, mark_d;
  logic                      phase_q, phase_d;
  logic [INTERVAL_MAX_W-1:0] sample_ext;
  logic [COUNTER_BITS-1:0]   sample;
  logic [COUNTER_BITS-1:0]   diff;
  logic                      accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  assign sample_ext = INTERVAL_MAX_W'(in_item_i.counter_value);
  assign sample     = sample_ext[COUNTER_BITS-1:0];
  // wraps modulo the counter range
  assign diff       = sample - mark_q;

  always_comb begin
    mark_d          = mark_q;
    phase_d         = phase_q;
    cmd_o.op        = OP_HOLD;
    cmd_o.interval  = INTERVAL_MAX_W'(diff);
    unique case (mode_e'(in_item_i.mode))
      MODE_MARK: begin
        if (accept) mark_d = sample;
      end
      MODE_FREQ: begin
        if (accept) phase_d = !phase_q;
        if (!phase_q) begin
          // first of a pair: restart the interval
          if (accept) mark_d = sample;
        end else begin
          cmd_o.op = OP_FREQ;
        end
      end
      MODE_ELAPSED: begin
        cmd_o.op = OP_ELAPSED;
      end
      MODE_UNUSED: begin
        cmd_o.op = OP_HOLD;
      end
      default: begin
        cmd_o.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      mark_q  <= mark_d;
      phase_q <= phase_d;
    end
  end

  a_phase_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.mode == MODE_FREQ) |=> (phase_q != $past(phase_q)))
    else $error("phase did not toggle on frequency request");

endmodule

FILE: rtl/trem_queue.sv
module trem_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  trem_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output trem_pkg::cmd_t cmd_o
);
  import trem_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: rtl/trem_back.sv
module trem_back #(
  parameter int COUNTER_BITS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [trem_pkg::TICK_W-1:0]   tick_rate_i,
  input  logic                          valid_i,
  input  trem_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output trem_pkg::out_item_t           out_item_o
);
  import trem_pkg::*;

  // wide enough for the elapsed numerator and for twice the tick rate plus an interval
  localparam int NUMW   = (COUNTER_BITS + FRACTION_BITS + 11 > TICK_W + 2) ?
                          COUNTER_BITS + FRACTION_BITS + 11 : TICK_W + 2;
  localparam int DENW   = (COUNTER_BITS + 1 > TICK_W) ? COUNTER_BITS + 1 : TICK_W;
  localparam int CNT_W  = $clog2(NUMW + 1);
  localparam int PROD_W = COUNTER_BITS + MS_W;

  back_state_e         state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [NUMW-1:0]     num_q, num_d;
  logic [DENW-1:0]     den_q, den_d;
  logic [DENW-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                zero_q, zero_d;
  logic [FREQ_W-1:0]   held_q, held_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic [COUNTER_BITS-1:0] interval;
  logic [PROD_W-1:0]       prod;
  logic [DENW:0]           partial;
  logic [DENW+1:0]         trial;
  logic                    ge;
  logic                    out_load;
  out_item_t               res;

  assign interval = cmd_q.interval[COUNTER_BITS-1:0];
  assign prod     = PROD_W'(interval) * PROD_W'(MS_PER_S);
  assign partial  = {rem_q, num_q[NUMW-1]};
  assign trial    = {1'b0, partial} - {2'b00, den_q};
  assign ge       = !trial[DENW+1];
  assign out_load = (state_q == BK_DONE) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == BK_IDLE) && valid_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (valid_i) state_d = (cmd_i.op == OP_HOLD) ? BK_DONE : BK_PREP;
      end
      BK_PREP: state_d = BK_BIAS;
      BK_BIAS: state_d = (den_q == '0) ? BK_DONE : BK_DIV;
      BK_DIV: begin
        if (cnt_q == CNT_W'(NUMW - 1)) state_d = BK_DONE;
      end
      BK_DONE: begin
        if (out_load) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // result from the finished quotient
  always_comb begin
    res.freq_hz        = held_q;
    res.elapsed_ms_q8  = '0;
    res.freq_saturated = 1'b0;
    res.freq_fresh     = 1'b0;
    unique case (cmd_q.op)
      OP_FREQ: begin
        res.freq_fresh = 1'b1;
        if (zero_q || (|num_q[NUMW-1:FREQ_W])) begin
          res.freq_hz        = FREQ_MAX;
          res.freq_saturated = 1'b1;
        end else begin
          res.freq_hz = num_q[FREQ_W-1:0];
        end
      end
      OP_ELAPSED: begin
        if (zero_q || (|num_q[NUMW-1:ELAPSED_W])) begin
          res.elapsed_ms_q8 = ELAPSED_MAX;
        end else begin
          res.elapsed_ms_q8 = num_q[ELAPSED_W-1:0];
        end
      end
      default: begin
        res.freq_hz = held_q;
      end
    endcase
  end

  // datapath
  always_comb begin
    cmd_d  = cmd_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    zero_d = zero_q;
    held_d = held_q;
    out_d  = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          cmd_d  = cmd_i;
          zero_d = 1'b0;
        end
      end
      BK_PREP: begin
        if (cmd_q.op == OP_FREQ) begin
          num_d = NUMW'(tick_rate_i) << 1;
          den_d = DENW'(interval) << 1;
        end else begin
          num_d = NUMW'(prod) << FRACTION_BITS;
          den_d = DENW'(tick_rate_i);
        end
      end
      BK_BIAS: begin
        // add the half-divisor so the quotient rounds half up
        zero_d = (den_q == '0);
        if (cmd_q.op == OP_FREQ) begin
          num_d = num_q + NUMW'(interval);
        end else begin
          num_d = num_q + NUMW'(tick_rate_i >> 1);
        end
        rem_d = '0;
        cnt_d = '0;
      end
      BK_DIV: begin
        rem_d = ge ? trial[DENW-1:0] : partial[DENW-1:0];
        num_d = {num_q[NUMW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
      end
      BK_DONE: begin
        if (out_load) begin
          out_d       = res;
          out_valid_d = 1'b1;
          held_d      = res.freq_hz;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      zero_q      <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (cnt_q < CNT_W'(NUMW)))
    else $error("divider step count overran");

  a_fresh_no_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.freq_fresh) |-> (out_q.elapsed_ms_q8 == '0))
    else $error("fresh frequency result carries elapsed time");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DONE && !out_load) |=> (state_q == BK_DONE))
    else $error("result dropped while output held");

endmodule

FILE: rtl/task_rate_and_elapsed_meter.sv
// Mark, hold and first-of-pair frequency requests skip the divider and go from idle
// straight to the done state; interval divides pass through prep, bias and the divide
// steps (a zero divisor skips the divide steps) to fill a quotient of width W, where
// W = max(COUNTER_BITS + FRACTION_BITS + 11, 26). The one-bit-per-cycle restoring
// divider takes one request at a time; a two-entry queue lets requests arrive meanwhile.
// Reset: clears start mark, phase, held frequency, queue and output; tick_rate_hz
// returns to 100000.
module task_rate_and_elapsed_meter #(
  parameter int COUNTER_BITS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  trem_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output trem_pkg::out_item_t             out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [trem_pkg::PADDR_W-1:0]    paddr,
  input  logic [trem_pkg::PDATA_W-1:0]    pwdata,
  output logic [trem_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import trem_pkg::*;

  logic [TICK_W-1:0] tick_rate_q, tick_rate_d;
  logic              cfg_write;
  logic              reg_idx;

  logic push, full, pop, q_valid;
  cmd_t front_cmd, back_cmd;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready && (reg_idx == REG_TICK_RATE);
  assign tick_rate_d = cfg_write ? pwdata[TICK_W-1:0] : tick_rate_q;
  assign prdata    = (reg_idx == REG_TICK_RATE) ? PDATA_W'(tick_rate_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= TICK_RATE_RESET;
    end else begin
      tick_rate_q <= tick_rate_d;
    end
  end

  trem_front #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  trem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  trem_back #(
    .COUNTER_BITS  (COUNTER_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_rate_i (tick_rate_q),
    .valid_i     (q_valid),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: dv/task_rate_and_elapsed_meter_tb.sv
module task_rate_and_elapsed_meter_tb;
  import trem_pkg::*;

  localparam int FRAC_BITS     = 8;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 750;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [PADDR_W-1:0]   paddr       = '0;
  logic [PDATA_W-1:0]   pwdata      = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Predicted block state
  logic [TICK_W-1:0]    tick_rate_q = TICK_RATE_RESET;
  logic [SAMPLE_W-1:0]  mark_q      = '0;
  logic                 phase_q     = 1'b0;
  logic [FREQ_W-1:0]    held_freq_q = '0;

  out_item_t            pending_results[$];
  int                   fail_count  = 0;
  int                   cycle_count = 0;
  bit                   calm        = 1'b0;

  task_rate_and_elapsed_meter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 25);
  endfunction

  always @(negedge clk_i) begin
    out_stall_i = idle_roll();
  end

  // Advance the predicted meter by one request and return its report.
  function automatic out_item_t meter_predict(in_item_t req);
    out_item_t          res;
    logic [SAMPLE_W-1:0] span;
    longint unsigned    rate, ticks, quot, num;
    res = '0;
    res.freq_hz = held_freq_q;
    span = req.counter_value - mark_q;
    rate = longint'(tick_rate_q);
    ticks = longint'(span);
    case (mode_e'(req.mode))
      MODE_MARK: begin
        mark_q = req.counter_value;
      end
      MODE_FREQ: begin
        phase_q = ~phase_q;
        if (phase_q) begin
          mark_q = req.counter_value;
        end else begin
          if (ticks == 0) begin
            quot = longint'(FREQ_MAX);
            res.freq_saturated = 1'b1;
          end else begin
            quot = (2 * rate + ticks) / (2 * ticks);
            if (quot > longint'(FREQ_MAX)) begin
              quot = longint'(FREQ_MAX);
              res.freq_saturated = 1'b1;
            end
          end
          held_freq_q = quot[FREQ_W-1:0];
          res.freq_hz = held_freq_q;
          res.freq_fresh = 1'b1;
        end
      end
      MODE_ELAPSED: begin
        if (rate == 0) begin
          res.elapsed_ms_q8 = ELAPSED_MAX;
        end else begin
          num = (ticks * longint'(MS_PER_S)) << FRAC_BITS;
          quot = (num + rate / 2) / rate;
          if (quot > longint'(ELAPSED_MAX)) quot = longint'(ELAPSED_MAX);
          res.elapsed_ms_q8 = quot[ELAPSED_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", out_item_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.freq_hz !== want.freq_hz) begin
          $error("freq_hz expected %0d actual %0d", want.freq_hz, out_item_o.freq_hz);
          fail_count++;
        end
        if (out_item_o.elapsed_ms_q8 !== want.elapsed_ms_q8) begin
          $error("elapsed_ms_q8 expected %0d actual %0d",
                 want.elapsed_ms_q8, out_item_o.elapsed_ms_q8);
          fail_count++;
        end
        if (out_item_o.freq_saturated !== want.freq_saturated) begin
          $error("freq_saturated expected %0b actual %0b",
                 want.freq_saturated, out_item_o.freq_saturated);
          fail_count++;
        end
        if (out_item_o.freq_fresh !== want.freq_fresh) begin
          $error("freq_fresh expected %0b actual %0b",
                 want.freq_fresh, out_item_o.freq_fresh);
          fail_count++;
        end
      end
    end
  end

  task automatic send_request(mode_e mode, logic [SAMPLE_W-1:0] sample);
    in_item_t req;
    req.mode = mode;
    req.counter_value = sample;
    @(negedge clk_i);
    while (idle_roll()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = req;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(meter_predict(req));
  endtask

  // Drop valid and hold until every report has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_access(bit is_write, logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = is_write;
    paddr = {REG_TICK_RATE, 2'b00};
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_tick_rate();
    logic [PDATA_W-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata !== PDATA_W'(tick_rate_q)) begin
      $error("tick_rate_hz expected %0d actual %0d", tick_rate_q, rdata);
      fail_count++;
    end
  endtask

  task automatic set_tick_rate(logic [TICK_W-1:0] rate);
    logic [PDATA_W-1:0] unused;
    settle();
    apb_access(1'b1, PDATA_W'(rate), unused);
    tick_rate_q = rate;
    check_tick_rate();
  endtask

  task automatic test_register_reset();
    check_tick_rate();
  endtask

  task automatic test_directed();
    send_request(MODE_MARK, 16'h0000);
    send_request(MODE_ELAPSED, 16'h0000);
    send_request(MODE_ELAPSED, 16'hFFFF);
    // zero interval saturates
    send_request(MODE_FREQ, 16'hFFFF);
    send_request(MODE_FREQ, 16'hFFFF);
    // quotient above range
    send_request(MODE_FREQ, 16'h0000);
    send_request(MODE_FREQ, 16'h0001);
    // timer wrap between the two calls
    send_request(MODE_FREQ, 16'hFFF0);
    send_request(MODE_FREQ, 16'h0010);
    send_request(MODE_FREQ, 16'h0064);
    send_request(MODE_FREQ, 16'h0063);
    send_request(MODE_UNUSED, 16'hFFFF);
    send_request(MODE_MARK, 16'hFFFF);
    send_request(MODE_ELAPSED, 16'hFFFE);
    send_request(MODE_ELAPSED, 16'h8000);
    send_request(MODE_FREQ, 16'h5555);
    send_request(MODE_FREQ, 16'hAAAA);
    send_request(MODE_UNUSED, 16'h0000);
    send_request(MODE_ELAPSED, 16'h5554);
  endtask

  task automatic test_rate_extremes();
    logic [TICK_W-1:0] rates[6];
    rates = '{24'd1000, 24'd10000000, 24'hFFFFFF, 24'd0, 24'd1, TICK_RATE_RESET};
    foreach (rates[i]) begin
      set_tick_rate(rates[i]);
      send_request(MODE_MARK, 16'($urandom));
      send_request(MODE_ELAPSED, mark_q - 16'd1);
      send_request(MODE_ELAPSED, 16'($urandom));
      send_request(MODE_FREQ, 16'($urandom));
      send_request(MODE_FREQ, mark_q + 16'($urandom_range(200)));
      send_request(MODE_FREQ, 16'($urandom));
      send_request(MODE_FREQ, 16'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int    pick;
    mode_e mode;
    logic [SAMPLE_W-1:0] sample;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        set_tick_rate(TICK_W'($urandom_range(10000000, 1000)));
      end else if ($urandom_range(59) == 0) begin
        settle();
      end
      calm = (n >= 300 && n < 420);
      pick = $urandom_range(99);
      if (pick < 20) mode = MODE_MARK;
      else if (pick < 60) mode = MODE_FREQ;
      else if (pick < 90) mode = MODE_ELAPSED;
      else mode = MODE_UNUSED;
      // short intervals reach the saturating end of the divide
      if ($urandom_range(2) == 0) sample = mark_q + 16'($urandom_range(80));
      else sample = 16'($urandom);
      send_request(mode, sample);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_register_reset();
    test_directed();
    test_rate_extremes();
    test_random_traffic();
    settle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
